@@ rtl/lsdq_pkg.sv @@
package lsdq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int COORD_BITS  = 12;

	// Port field widths
	localparam int LAYER_BITS   = 8;
	localparam int IO_COORD     = 12;
	localparam int SURFACE_BITS = 16;
	localparam int DATA_BITS    = LAYER_BITS + 6 * IO_COORD + SURFACE_BITS;

	// Request kinds carried on the input tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// One stored draw command
	typedef struct packed {
		logic [SURFACE_BITS-1:0] surface_id;
		logic [COORD_BITS-1:0]   dst_y;
		logic [COORD_BITS-1:0]   dst_x;
		logic [COORD_BITS-1:0]   src_h;
		logic [COORD_BITS-1:0]   src_w;
		logic [COORD_BITS-1:0]   src_y;
		logic [COORD_BITS-1:0]   src_x;
		logic [LAYER_BITS-1:0]   layer;
	} entry_t;

	// Chain control shared by every cell
	typedef struct packed {
		logic ins_en;
		logic pop_en;
	} chain_ctl_t;

	// Port coordinate to stored coordinate
	function automatic logic [COORD_BITS-1:0] to_coord(input logic [IO_COORD-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		return wide[COORD_BITS-1:0];
	endfunction

	// Stored coordinate to port coordinate
	function automatic logic [IO_COORD-1:0] from_coord(input logic [COORD_BITS-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		return wide[IO_COORD-1:0];
	endfunction

endpackage

@@ rtl/lsdq_cell.sv @@
module lsdq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lsdq_pkg::chain_ctl_t ctl,
	input  lsdq_pkg::entry_t    new_ent,
	input  lsdq_pkg::entry_t    prv_ent,
	input  logic                prv_occ,
	input  logic                prv_ins,
	input  lsdq_pkg::entry_t    nxt_ent,
	input  logic                nxt_occ,
	output lsdq_pkg::entry_t    ent,
	output logic                occ,
	output logic                ins
);
	import lsdq_pkg::*;

	entry_t ent_q;
	logic   occ_q;

	// An occupied cell with a strictly greater layer, or an empty one, lies at or past the slot
	assign ins = !occ_q || (ent_q.layer > new_ent.layer);
	assign ent = ent_q;
	assign occ = occ_q;

	// Advance occupancy: shift down on a pop, shift up or take the new command on an insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.pop_en) begin
			occ_q <= nxt_occ;
		end else if (ctl.ins_en && ins) begin
			occ_q <= prv_ins ? prv_occ : 1'b1;
		end
	end

	// Move the payload alongside
	always_ff @(posedge clk) begin
		if (ctl.pop_en) begin
			ent_q <= nxt_ent;
		end else if (ctl.ins_en && ins) begin
			ent_q <= prv_ins ? prv_ent : new_ent;
		end
	end

endmodule

@@ rtl/lsdq_chain.sv @@
module lsdq_chain (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lsdq_pkg::chain_ctl_t                ctl,
	input  lsdq_pkg::entry_t                    new_ent,
	output lsdq_pkg::entry_t                    head_ent,
	output logic [lsdq_pkg::QUEUE_DEPTH-1:0]    occ_vec
);
	import lsdq_pkg::*;

	entry_t ent_c [QUEUE_DEPTH];
	logic   occ_c [QUEUE_DEPTH];
	logic   ins_c [QUEUE_DEPTH];

	// Build the row of cells, each wired to its neighbours
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		entry_t prv_e;
		logic   prv_o;
		logic   prv_i;
		entry_t nxt_e;
		logic   nxt_o;

		if (k == 0) begin : g_head
			assign prv_e = '0;
			assign prv_o = 1'b0;
			assign prv_i = 1'b0;
		end else begin : g_mid
			assign prv_e = ent_c[k-1];
			assign prv_o = occ_c[k-1];
			assign prv_i = ins_c[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt_e = '0;
			assign nxt_o = 1'b0;
		end else begin : g_body
			assign nxt_e = ent_c[k+1];
			assign nxt_o = occ_c[k+1];
		end

		lsdq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_ent (new_ent),
			.prv_ent (prv_e),
			.prv_occ (prv_o),
			.prv_ins (prv_i),
			.nxt_ent (nxt_e),
			.nxt_occ (nxt_o),
			.ent     (ent_c[k]),
			.occ     (occ_c[k]),
			.ins     (ins_c[k])
		);

		assign occ_vec[k] = occ_c[k];
	end

	assign head_ent = ent_c[0];

endmodule

@@ rtl/layer_sorted_draw_queue.sv @@
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tdata: draw command, s_tuser: opcode
// m        out  m_tvalid/m_tready  m_tdata: draw command, m_tuser: overflowed, m_tlast
//
// Ready stays high while idle, so inserts follow back to back.
// A flush holds the input off while the stored entries leave, one entry a cycle
// when the sink is not stalling, as the cell chain shifts toward the output
// register; an empty flush never leaves idle. The output register holds the
// last result while further inserts are taken.
// Reset clears occupancy, the drop flag, the sequencer and the output valid.
module layer_sorted_draw_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// layer, src_x, src_y, src_w, src_h, dst_x, dst_y, surface_id
	input  logic [lsdq_pkg::DATA_BITS-1:0] s_tdata,
	// opcode
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_layer, out_src_x, out_src_y, out_src_w, out_src_h, out_dst_x, out_dst_y,
	// out_surface_id
	output logic [lsdq_pkg::DATA_BITS-1:0] m_tdata,
	// overflowed
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import lsdq_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FLUSH = 1'b1;

	logic                   state_q;
	logic                   dropped_q;
	logic                   ovf_q;
	logic                   out_vld_q;
	logic                   out_last_q;
	logic                   out_ovf_q;
	logic [DATA_BITS-1:0]   out_data_q;
	entry_t                 new_ent;
	entry_t                 head_ent;
	logic [QUEUE_DEPTH-1:0] occ_vec;
	chain_ctl_t             ctl;
	logic                   req;
	logic                   full;
	logic                   pop;
	logic                   head_last;

	// Unpack the incoming command
	assign new_ent.layer      = s_tdata[7:0];
	assign new_ent.src_x      = to_coord(s_tdata[19:8]);
	assign new_ent.src_y      = to_coord(s_tdata[31:20]);
	assign new_ent.src_w      = to_coord(s_tdata[43:32]);
	assign new_ent.src_h      = to_coord(s_tdata[55:44]);
	assign new_ent.dst_x      = to_coord(s_tdata[67:56]);
	assign new_ent.dst_y      = to_coord(s_tdata[79:68]);
	assign new_ent.surface_id = s_tdata[95:80];

	assign s_tready  = (state_q == ST_IDLE);
	assign req       = s_tvalid && s_tready;
	assign full      = occ_vec[QUEUE_DEPTH-1];
	assign pop       = (state_q == ST_FLUSH) && (!out_vld_q || m_tready);
	assign head_last = ~|(occ_vec >> 1);

	assign ctl.ins_en = req && (s_tuser == OP_INSERT) && !full;
	assign ctl.pop_en = pop;

	lsdq_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.new_ent  (new_ent),
		.head_ent (head_ent),
		.occ_vec  (occ_vec)
	);

	// Sequence flushes and keep the sticky drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dropped_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req && (s_tuser == OP_INSERT) && full) begin
						dropped_q <= 1'b1;
					end else if (req && (s_tuser == OP_FLUSH)) begin
						ovf_q     <= dropped_q;
						dropped_q <= 1'b0;
						if (occ_vec[0]) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (pop && head_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {head_ent.surface_id,
				from_coord(head_ent.dst_y), from_coord(head_ent.dst_x),
				from_coord(head_ent.src_h), from_coord(head_ent.src_w),
				from_coord(head_ent.src_y), from_coord(head_ent.src_x),
				head_ent.layer};
			out_last_q <= head_last;
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ovf_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	// Occupancy stays a contiguous run from the head
	a_occ_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec + QUEUE_DEPTH'(1)) & occ_vec) == '0)
		else $error("occupancy not contiguous");

	// A flush only runs while the head cell holds an entry
	a_flush_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> occ_vec[0])
		else $error("flush with empty chain");

	// A pop never overwrites a result the sink has not taken
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!m_tvalid || m_tready))
		else $error("result overwritten");

	// The final pop of a run leaves the sequencer idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_last) |=> (state_q == ST_IDLE))
		else $error("flush still running after last result");

	// An insert into a full queue raises the drop flag
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(req && (s_tuser == OP_INSERT) && full) |=> dropped_q)
		else $error("drop not recorded");
`endif

endmodule

@@ tb/sv/lsdq_order_checker.sv @@
`timescale 1ns / 100ps

// Watch both channels of the draw queue, keep a shadow of the sorted frame and
// compare every emitted draw command with the oldest one still owed.
module lsdq_order_checker
	import lsdq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// layer, src_x, src_y, src_w, src_h, dst_x, dst_y, surface_id
	input  logic [DATA_BITS-1:0] s_tdata,
	// opcode
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// out_layer, out_src_x, out_src_y, out_src_w, out_src_h, out_dst_x, out_dst_y,
	// out_surface_id
	input  logic [DATA_BITS-1:0] m_tdata,
	// overflowed
	input  logic                 m_tuser,
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   outstanding,
	output int                   draws_checked,
	output int                   overflow_flushes
);

	typedef struct {
		entry_t cmd;
		logic   overflowed;
		logic   last;
	} owed_draw_t;

	entry_t     frame_cmds[$];
	owed_draw_t owed_draws[$];
	logic       drop_seen;
	int         reported;

	initial begin
		mismatches       = 0;
		outstanding      = 0;
		draws_checked    = 0;
		overflow_flushes = 0;
		reported         = 0;
		drop_seen        = 1'b0;
	end

	// Count a failure, print only the first few
	task automatic note_failure(input string msg);
		mismatches++;
		if (reported < 10) begin
			$display("%0t: %s", $realtime, msg);
			reported++;
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got)
			note_failure($sformatf("draw %0d, %s: expected %0h, got %0h",
				draws_checked, name, want, got));
	endtask

	// Accepted requests first, so a result can never overtake its own flush
	always @(posedge clk or negedge arst_n) begin : watch
		entry_t     cmd;
		entry_t     got;
		owed_draw_t want;
		int         slot;
		if (!arst_n) begin
			frame_cmds.delete();
			owed_draws.delete();
			drop_seen   = 1'b0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				cmd = entry_t'(s_tdata);
				if (s_tuser == OP_INSERT) begin
					if (frame_cmds.size() >= QUEUE_DEPTH) begin
						// full: drop the command, remember the loss
						drop_seen = 1'b1;
					end else begin
						// stable insert: after every entry of equal or lower layer
						slot = frame_cmds.size();
						for (int k = 0; k < frame_cmds.size(); k++) begin
							if (frame_cmds[k].layer > cmd.layer) begin
								slot = k;
								break;
							end
						end
						frame_cmds.insert(slot, cmd);
					end
				end else begin
					// flush: owe every stored command in order, then empty
					foreach (frame_cmds[k]) begin
						want.cmd        = frame_cmds[k];
						want.overflowed = drop_seen;
						want.last       = (k == frame_cmds.size() - 1);
						owed_draws.push_back(want);
					end
					if (drop_seen)
						overflow_flushes++;
					frame_cmds.delete();
					drop_seen = 1'b0;
				end
			end

			if (m_tvalid && m_tready) begin
				got = entry_t'(m_tdata);
				if (owed_draws.size() == 0) begin
					note_failure($sformatf("unexpected draw: layer %0h surface %0h",
						got.layer, got.surface_id));
				end else begin
					want = owed_draws.pop_front();
					check_field("layer", want.cmd.layer, got.layer);
					check_field("src_x", want.cmd.src_x, got.src_x);
					check_field("src_y", want.cmd.src_y, got.src_y);
					check_field("src_w", want.cmd.src_w, got.src_w);
					check_field("src_h", want.cmd.src_h, got.src_h);
					check_field("dst_x", want.cmd.dst_x, got.dst_x);
					check_field("dst_y", want.cmd.dst_y, got.dst_y);
					check_field("surface_id", want.cmd.surface_id, got.surface_id);
					check_field("overflowed", want.overflowed, m_tuser);
					check_field("last_of_run", want.last, m_tlast);
					draws_checked++;
				end
			end
			outstanding = owed_draws.size();
		end
	end

endmodule

@@ tb/sv/tb_layer_sorted_draw_queue.sv @@
`timescale 1ns / 100ps

module tb_layer_sorted_draw_queue;
	import lsdq_pkg::*;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_BITS-1:0] s_tdata  = '0;
	logic                 s_tuser  = OP_INSERT;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_BITS-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	int mismatches;
	int outstanding;
	int draws_checked;
	int overflow_flushes;

	int src_idle_pct  = 19;
	int sink_idle_pct = 87;
	int insert_count  = 0;
	int flush_count   = 0;

	always #4 clk = ~clk;

	layer_sorted_draw_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lsdq_order_checker order_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tlast          (m_tlast),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.draws_checked    (draws_checked),
		.overflow_flushes (overflow_flushes)
	);

	// Stall the sink at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// Random draw command at a given layer
	function automatic entry_t random_draw(input logic [LAYER_BITS-1:0] lay);
		entry_t cmd;
		cmd            = entry_t'({$urandom, $urandom, $urandom});
		cmd.layer      = lay;
		return cmd;
	endfunction

	function automatic logic [LAYER_BITS-1:0] random_layer();
		case ($urandom_range(3))
			0:       return LAYER_BITS'($urandom_range(3));
			1:       return $urandom_range(1) ? '1 : '0;
			default: return LAYER_BITS'($urandom);
		endcase
	endfunction

	// Offer one request at a falling edge and hold it until taken
	task automatic send_request(input logic op, input entry_t cmd);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		if (op == OP_INSERT)
			insert_count++;
		else
			flush_count++;
	endtask

	// Hold off new requests until every owed draw has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin : limit
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int frame_no;
		int frame_len;
		int phase;
		int next_phase;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty flush, field extremes, equal layers, single entry
		send_request(OP_FLUSH, random_draw(8'd9));
		send_request(OP_INSERT, entry_t'('1));
		send_request(OP_INSERT, entry_t'('0));
		for (int k = 1; k <= 3; k++) begin
			send_request(OP_INSERT, random_draw(8'd128));
		end
		send_request(OP_INSERT, random_draw(8'd0));
		send_request(OP_INSERT, random_draw(8'd255));
		send_request(OP_INSERT, random_draw(8'd127));
		send_request(OP_FLUSH, random_draw(8'd0));
		send_request(OP_FLUSH, random_draw(8'd255));
		send_request(OP_INSERT, random_draw(8'd7));
		send_request(OP_FLUSH, random_draw(8'd7));
		wait_drained();

		// Random frames, with idle pattern changing as the run goes on
		frame_no = 0;
		phase    = 0;
		while (insert_count + flush_count < 410) begin
			next_phase = (insert_count + flush_count < 150) ? 0 :
				(insert_count + flush_count < 290) ? 1 : 2;
			if (next_phase != phase) begin
				wait_drained();
				phase         = next_phase;
				src_idle_pct  = (phase == 1) ? 87 : 0;
				sink_idle_pct = (phase == 1) ? 19 : 0;
			end

			if (frame_no % 8 == 2)
				frame_len = QUEUE_DEPTH + $urandom_range(8);
			else if (frame_no % 8 == 5)
				frame_len = 0;
			else
				frame_len = $urandom_range(1, 12);

			if (frame_no % 5 == 4) begin
				// broken frame: flushes scattered among inserts
				repeat (frame_len) begin
					send_request(($urandom_range(3) == 0) ? OP_FLUSH : OP_INSERT,
						random_draw(random_layer()));
				end
			end else begin
				repeat (frame_len)
					send_request(OP_INSERT, random_draw(random_layer()));
				send_request(OP_FLUSH, random_draw(random_layer()));
			end
			frame_no++;
		end

		// Drain, then watch a while longer for stray results
		wait_drained();
		repeat (60) @(negedge clk);

		$display("Sent %0d inserts and %0d flushes over %0d frames under three idle patterns.",
			insert_count, flush_count, frame_no);
		$display("Compared %0d draw commands; %0d flushes carried the dropped-insert flag.",
			draws_checked, overflow_flushes);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
